[hw/rtl/psched_pkg.sv]
// Package for the priority scheduler: field widths, item structs, controller states
// and the command and status bundles between controller and datapath.
// No dependencies.
package psched_pkg;

    localparam int MAX_PROCS_DEF = 32;

    localparam int BURST_W     = 16;
    localparam int PRIO_W      = 8;
    localparam int INDEX_W     = 5;
    localparam int TIME_W      = 21;
    localparam int TOTAL_W     = 26;
    localparam int AVG_W       = 29;
    localparam int AVG_SHIFT   = 8;
    localparam int ENTRY_W     = BURST_W + PRIO_W;
    localparam int BURST_MAX   = (1 << BURST_W) - 1;

    typedef struct packed {
        logic [BURST_W-1:0] burst_time;
        logic [PRIO_W-1:0]  prio_value;
        logic               is_final;
    } in_item_t;

    typedef struct packed {
        logic [INDEX_W-1:0] proc_index;
        logic [BURST_W-1:0] proc_burst;
        logic [PRIO_W-1:0]  proc_prio;
        logic [TIME_W-1:0]  wait_time;
        logic [TIME_W-1:0]  turnaround_time;
        logic [TOTAL_W-1:0] total_wait;
        logic [TOTAL_W-1:0] total_turnaround;
        logic [AVG_W-1:0]   avg_wait_q8;
        logic [AVG_W-1:0]   avg_turnaround_q8;
        logic               overflow_flag;
        logic               last_result;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_STEP,
        ST_DIVW_GO,
        ST_DIVW_WAIT,
        ST_DIVT_GO,
        ST_DIVT_WAIT
    } psched_state_t;

    typedef struct packed {
        logic load;        // store the accepted item
        logic scan_start;  // restart the minimum search
        logic scan;        // search in progress
        logic take;        // schedule the search winner
        logic div_start;   // launch a division
        logic div_sel;     // 0: waiting total, 1: turnaround total
        logic latch_avg_w; // capture the average waiting time
        logic finish;      // emit the final item and clear the batch
    } dp_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic last_pos;
        logic div_done;
    } dp_status_t;

endpackage

[hw/rtl/psched_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module psched_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/psched_div.sv]
// Restoring divider, one quotient bit per cycle, for the batch averages.
// No dependencies.
module psched_div #(
    parameter int DIVIDEND_W = 34,
    parameter int DIVISOR_W  = 6
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int STEP_W = $clog2(DIVIDEND_W + 1);

    logic                  run_reg, run_next;
    logic                  done_reg, done_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dsr_reg, dsr_next;
    logic [DIVISOR_W:0]    trial;
    logic                  fits;

    // The dividend shifts out of the top of quo_reg as quotient bits shift in.
    always_comb
    begin
        trial     = {rem_reg, quo_reg[DIVIDEND_W-1]};
        fits      = (trial >= {1'b0, dsr_reg});
        run_next  = run_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            run_next  = 1'b1;
            step_next = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (run_reg)
        begin
            rem_next  = fits ? DIVISOR_W'(trial - {1'b0, dsr_reg}) : DIVISOR_W'(trial);
            quo_next  = {quo_reg[DIVIDEND_W-2:0], fits};
            step_next = STEP_W'(step_reg + 1'b1);
            if (step_reg == STEP_W'(DIVIDEND_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[hw/rtl/psched_ctrl.sv]
// Controller state machine for the priority scheduler.
// Depends on psched_pkg for the state type and the command and status bundles.
module psched_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   item_final,
    input  psched_pkg::dp_status_t status,
    output psched_pkg::dp_cmd_t    cmd,
    output logic                   busy
);

    import psched_pkg::*;

    psched_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (item_final)
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_done)
                begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                cmd.take = 1'b1;
                if (status.last_pos)
                begin
                    state_next = ST_DIVW_GO;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_DIVW_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIVW_WAIT;
            end
            ST_DIVW_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.latch_avg_w = 1'b1;
                    state_next      = ST_DIVT_GO;
                end
            end
            ST_DIVT_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = 1'b1;
                state_next    = ST_DIVT_WAIT;
            end
            ST_DIVT_WAIT:
            begin
                cmd.div_sel = 1'b1;
                if (status.div_done)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/psched_dp.sv]
// Datapath for the priority scheduler: process store, minimum search, prefix sums,
// divider and result register. Depends on psched_pkg, psched_ram and psched_div.
module psched_dp #(
    parameter int MAX_PROCS = psched_pkg::MAX_PROCS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  psched_pkg::in_item_t   item,
    input  psched_pkg::dp_cmd_t    cmd,
    output psched_pkg::dp_status_t status,
    output logic                   result_valid,
    output psched_pkg::out_item_t  result
);

    import psched_pkg::*;

    localparam int IW = $clog2(MAX_PROCS);
    localparam int CW = $clog2(MAX_PROCS + 1);
    localparam int KW = PRIO_W + IW;
    localparam int PW = $clog2(MAX_PROCS * BURST_MAX + 1);
    localparam int SW = $clog2(MAX_PROCS * (MAX_PROCS + 1) / 2 * BURST_MAX + 1);
    localparam int DW = SW + AVG_SHIFT;

    // Control state
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          ovf_reg, ovf_next;
    logic [CW-1:0] j_reg, j_next;
    logic          pend_reg, pend_next;
    logic          best_valid_reg, best_valid_next;
    logic          have_last_reg, have_last_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [PW-1:0] pre_reg, pre_next;
    logic [SW-1:0] sum_w_reg, sum_w_next;
    logic [SW-1:0] sum_t_reg, sum_t_next;
    logic          valid_reg, valid_next;

    // Payload state
    logic [IW-1:0]      pidx_reg, pidx_next;
    logic [KW-1:0]      best_key_reg, best_key_next;
    logic [BURST_W-1:0] best_burst_reg, best_burst_next;
    logic [KW-1:0]      last_key_reg, last_key_next;
    out_item_t          res_reg, res_next;

    logic               wr_en;
    logic               rd_en;
    logic [ENTRY_W-1:0] rdata;
    logic [BURST_W-1:0] rd_burst;
    logic [PRIO_W-1:0]  rd_prio;
    logic [KW-1:0]      cand_key;
    logic               above_last;
    logic               below_best;
    logic [PW-1:0]      turn;
    logic               last_pos;
    logic [DW-1:0]      div_dividend;
    logic               div_done;
    logic [DW-1:0]      div_quotient;

    assign wr_en = cmd.load && (cnt_reg < CW'(MAX_PROCS));
    assign rd_en = cmd.scan && (j_reg < cnt_reg);

    psched_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(MAX_PROCS)
    ) u_store (
        .clk  (clk),
        .we   (wr_en),
        .waddr(cnt_reg[IW-1:0]),
        .wdata({item.burst_time, item.prio_value}),
        .raddr(j_reg[IW-1:0]),
        .rdata(rdata)
    );

    assign div_dividend = cmd.div_sel ? {sum_t_reg, AVG_SHIFT'(0)} : {sum_w_reg, AVG_SHIFT'(0)};

    psched_div #(
        .DIVIDEND_W(DW),
        .DIVISOR_W (CW)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.div_start),
        .dividend(div_dividend),
        .divisor (cnt_reg),
        .done    (div_done),
        .quotient(div_quotient)
    );

    assign rd_burst   = rdata[ENTRY_W-1:PRIO_W];
    assign rd_prio    = rdata[PRIO_W-1:0];
    assign cand_key   = {rd_prio, pidx_reg};
    assign above_last = !have_last_reg || (cand_key > last_key_reg);
    assign below_best = !best_valid_reg || (cand_key < best_key_reg);
    assign turn       = PW'(pre_reg + PW'(best_burst_reg));
    assign last_pos   = (CW'(pos_reg + CW'(1)) == cnt_reg);

    assign status.scan_done = (j_reg == cnt_reg) && !pend_reg;
    assign status.last_pos  = last_pos;
    assign status.div_done  = div_done;

    always_comb
    begin
        cnt_next        = cnt_reg;
        ovf_next        = ovf_reg;
        j_next          = j_reg;
        pend_next       = rd_en;
        pidx_next       = j_reg[IW-1:0];
        best_valid_next = best_valid_reg;
        best_key_next   = best_key_reg;
        best_burst_next = best_burst_reg;
        have_last_next  = have_last_reg;
        last_key_next   = last_key_reg;
        pos_next        = pos_reg;
        pre_next        = pre_reg;
        sum_w_next      = sum_w_reg;
        sum_t_next      = sum_t_reg;
        valid_next      = 1'b0;
        res_next        = res_reg;

        if (cmd.load)
        begin
            if (wr_en)
            begin
                cnt_next = CW'(cnt_reg + CW'(1));
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end

        if (rd_en)
        begin
            j_next = CW'(j_reg + CW'(1));
        end

        // Keep the smallest (priority, arrival index) key above the last one taken.
        if (pend_reg && above_last && below_best)
        begin
            best_valid_next = 1'b1;
            best_key_next   = cand_key;
            best_burst_next = rd_burst;
        end

        if (cmd.take)
        begin
            have_last_next = 1'b1;
            last_key_next  = best_key_reg;
            pos_next       = CW'(pos_reg + CW'(1));
            pre_next       = turn;
            sum_w_next     = SW'(sum_w_reg + SW'(pre_reg));
            sum_t_next     = SW'(sum_t_reg + SW'(turn));

            res_next.proc_index        = INDEX_W'(best_key_reg[IW-1:0]);
            res_next.proc_burst        = best_burst_reg;
            res_next.proc_prio         = best_key_reg[KW-1:IW];
            res_next.wait_time         = TIME_W'(pre_reg);
            res_next.turnaround_time   = TIME_W'(turn);
            res_next.total_wait        = last_pos ? TOTAL_W'(sum_w_next) : '0;
            res_next.total_turnaround  = last_pos ? TOTAL_W'(sum_t_next) : '0;
            res_next.avg_wait_q8       = '0;
            res_next.avg_turnaround_q8 = '0;
            res_next.overflow_flag     = ovf_reg;
            res_next.last_result       = 1'b0;
            valid_next                 = !last_pos;
        end

        if (cmd.scan_start)
        begin
            j_next          = '0;
            pend_next       = 1'b0;
            best_valid_next = 1'b0;
        end

        if (cmd.latch_avg_w)
        begin
            res_next.avg_wait_q8 = AVG_W'(div_quotient);
        end

        if (cmd.finish)
        begin
            res_next.avg_turnaround_q8 = AVG_W'(div_quotient);
            res_next.last_result       = 1'b1;
            valid_next                 = 1'b1;
            cnt_next                   = '0;
            ovf_next                   = 1'b0;
            have_last_next             = 1'b0;
            pos_next                   = '0;
            pre_next                   = '0;
            sum_w_next                 = '0;
            sum_t_next                 = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            ovf_reg        <= 1'b0;
            j_reg          <= '0;
            pend_reg       <= 1'b0;
            best_valid_reg <= 1'b0;
            have_last_reg  <= 1'b0;
            pos_reg        <= '0;
            pre_reg        <= '0;
            sum_w_reg      <= '0;
            sum_t_reg      <= '0;
            valid_reg      <= 1'b0;
        end
        else
        begin
            cnt_reg        <= cnt_next;
            ovf_reg        <= ovf_next;
            j_reg          <= j_next;
            pend_reg       <= pend_next;
            best_valid_reg <= best_valid_next;
            have_last_reg  <= have_last_next;
            pos_reg        <= pos_next;
            pre_reg        <= pre_next;
            sum_w_reg      <= sum_w_next;
            sum_t_reg      <= sum_t_next;
            valid_reg      <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg       <= pidx_next;
        best_key_reg   <= best_key_next;
        best_burst_reg <= best_burst_next;
        last_key_reg   <= last_key_next;
        res_reg        <= res_next;
    end

    assign result_valid = valid_reg;
    assign result       = res_reg;

    // A search always finds a process that has not yet been scheduled.
    assert property (@(posedge clk) disable iff (!rst_n) cmd.take |-> best_valid_reg)
        else $error("scheduling step without a search winner");

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= CW'(MAX_PROCS))
        else $error("process count beyond capacity");

    assert property (@(posedge clk) disable iff (!rst_n) result_valid |=> !result_valid)
        else $error("result strobes in adjacent cycles");

endmodule

[hw/rtl/priority_schedule_times.sv]
// Top level of the non-preemptive priority scheduler.
// Depends on psched_pkg, psched_ctrl and psched_dp.
//
//  Channel   Handshake                  Payload
//  --------  -------------------------  --------------------------------------
//  input     start, busy (out)          item   : psched_pkg::in_item_t
//  result    result_valid (out)         result : psched_pkg::out_item_t
//
// An item that is not final is loaded and busy stays low.
// After the final item of a batch the block is busy while the minimum search
// and the bit-serial divider for the two averages run; the search reads the
// process store one entry a cycle for every scheduled position. The batch
// totals are SW bits wide, 26 at 32 processes. Reset clears the batch count,
// the overflow mark and the running sums; the process store itself is not
// cleared, since only entries of the current batch are ever read. The receiver
// cannot stall: each result is shown for exactly one cycle under result_valid,
// and the last one of a batch carries the totals and averages.
module priority_schedule_times #(
    parameter int MAX_PROCS = psched_pkg::MAX_PROCS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  psched_pkg::in_item_t  item,
    output logic                  result_valid,
    output psched_pkg::out_item_t result
);

    import psched_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // The controller sequences load, search, scheduling step and the two
    // divisions; the datapath holds the store and all arithmetic.
    psched_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item_final(item.is_final),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy)
    );

    psched_dp #(
        .MAX_PROCS(MAX_PROCS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .cmd         (cmd),
        .status      (status),
        .result_valid(result_valid),
        .result      (result)
    );

    // The final item of a batch is shown only once the block is ready again.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last_result |-> !busy)
        else $error("final item shown while the block is still busy");

endmodule
